[rtl/core/mmepid_pkg.sv]
// Shared types and constants for the multi-motor encoder position PID block.
// Holds register indexes, reset values, the per-motor state word and the sequencer codes.
// No dependencies; imported by the top level.

package mmepid_pkg;

	// Default number of motor channels.
	localparam int MOTOR_COUNT_DEF = 5;

	// Field widths of the stream items.
	localparam int MOTOR_W = 3;
	localparam int COUNT_W = 16;
	localparam int CMD_W   = 24;
	localparam int TOTAL_W = 32;

	// Configuration register indexes.
	localparam logic [2:0] REG_GAIN_P       = 3'd0;
	localparam logic [2:0] REG_GAIN_I       = 3'd1;
	localparam logic [2:0] REG_GAIN_D       = 3'd2;
	localparam logic [2:0] REG_MAX_INTEGRAL = 3'd3;
	localparam logic [2:0] REG_MAX_OUTPUT   = 3'd4;
	localparam logic [2:0] REG_COUNT_SCALE  = 3'd5;

	// Register values after reset.
	localparam logic [15:0] GAIN_P_RST       = 16'd2500;
	localparam logic [15:0] GAIN_I_RST       = 16'd50;
	localparam logic [15:0] GAIN_D_RST       = 16'd10000;
	localparam logic [23:0] MAX_INTEGRAL_RST = 24'd1000000;
	localparam logic [15:0] MAX_OUTPUT_RST   = 16'd65535;
	localparam logic [15:0] COUNT_SCALE_RST  = 16'd7253;

	// Per-motor state word kept in the state memory.
	typedef struct packed {
		logic [15:0] prev_count;
		logic [15:0] revolutions;
		logic [24:0] integral;
		logic [33:0] last_error;
	} mmepid_state_t;

	localparam int STATE_W = $bits(mmepid_state_t);

	// Sequencer states, one-hot.
	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_RD   = 7'b0000010,
		ST_ERR  = 7'b0000100,
		ST_MI   = 7'b0001000,
		ST_MP   = 7'b0010000,
		ST_MD   = 7'b0100000,
		ST_OUT  = 7'b1000000
	} mmepid_fsm_t;

endpackage

[rtl/core/mmepid_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Width and depth are parameters; no dependencies.

module mmepid_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/core/multi_motor_encoder_position_pid.sv]
// Top level of the multi-motor encoder position PID controller.
// Depends on mmepid_pkg and the generic state memory mmepid_ram.

// Each input item names a motor, its raw 16-bit encoder count and a position command in
// micrometers; each item yields exactly one result with direction, duty, a saturation flag
// and the unwrapped position. Items are processed one at a time: an item for a valid motor
// passes through the sequencer steps in order to the result register (the state memory read
// completes at the accepting edge, the RD, ERR, MI and MP steps drive the single shared
// 35x17 multiplier, the MD step adds the last product, the OUT step clamps and writes back);
// an item naming a motor at or above MOTOR_COUNT goes straight to the OUT step. The input
// is ready again right after the result is registered, even while that result waits to be
// taken; the last step stalls only while a previous result is still held. Per-motor state
// lives in a small memory whose entries read as zero until first written after reset, so
// no clearing pass is needed. Configuration writes are always taken.

module multi_motor_encoder_position_pid
	import mmepid_pkg::*;
#(
	parameter int MOTOR_COUNT = MOTOR_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream; s_tdata: motor[2:0], encoder_count[18:3], position_cmd[42:19], zeros above.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,
	// Result stream; m_tdata: motor_out[2:0], direction[3], duty[19:4], saturated[20],
	// position_total[52:21], zeros above.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	localparam int AW = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

	// Configuration registers.
	logic [15:0] gain_p_q;
	logic [15:0] gain_i_q;
	logic [15:0] gain_d_q;
	logic [23:0] max_integral_q;
	logic [15:0] max_output_q;
	logic [15:0] count_scale_q;

	// Sequencer and item registers.
	mmepid_fsm_t              state_q;
	logic [MOTOR_W-1:0]       motor_q;
	logic [COUNT_W-1:0]       raw_q;
	logic signed [CMD_W-1:0]  cmd_q;
	logic                     motor_ok_q;
	logic [AW-1:0]            addr_q;
	logic [MOTOR_COUNT-1:0]   valid_q;

	// Working registers.
	logic [15:0]              rev_q;
	logic signed [TOTAL_W-1:0] total_q;
	logic signed [24:0]       integ_q;
	logic signed [33:0]       lerr_q;
	logic signed [33:0]       error_q;
	logic signed [51:0]       mul_q;
	logic signed [52:0]       acc_q;

	// Output register.
	logic        m_tvalid_q;
	logic [55:0] m_tdata_q;

	// State memory signals.
	logic                 ram_we;
	logic [STATE_W-1:0]   ram_rdata;
	mmepid_state_t        ram_wword;
	mmepid_state_t        rd_word;

	logic                 s_fire;
	logic                 out_free;
	logic                 s_motor_ok;
	logic [MOTOR_W-1:0]   s_motor;

	// Unwrap and multiplier signals.
	logic signed [16:0]   cnt_diff;
	logic [15:0]          rev_next;
	logic signed [34:0]   mul_a;
	logic signed [16:0]   mul_b;
	logic signed [51:0]   mul_p;

	// Clamp signals.
	logic signed [52:0]   maxo_pos;
	logic signed [52:0]   maxo_neg;
	logic                 sat_hi;
	logic                 sat_lo;
	logic                 sat;
	logic                 out_pos;
	logic signed [52:0]   acc_abs;
	logic [15:0]          duty;
	logic signed [34:0]   integ_sum;
	logic signed [34:0]   integ_pre;
	logic signed [34:0]   maxi_pos;
	logic signed [34:0]   maxi_neg;
	logic signed [34:0]   integ_cl;

	assign s_fire     = s_tvalid && s_tready;
	assign s_tready   = (state_q == ST_IDLE);
	assign out_free   = !m_tvalid_q || m_tready;
	assign cfg_ready  = 1'b1;
	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign s_motor    = s_tdata[2:0];
	assign s_motor_ok = ({29'd0, s_motor} < 32'(MOTOR_COUNT));

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q       <= GAIN_P_RST;
			gain_i_q       <= GAIN_I_RST;
			gain_d_q       <= GAIN_D_RST;
			max_integral_q <= MAX_INTEGRAL_RST;
			max_output_q   <= MAX_OUTPUT_RST;
			count_scale_q  <= COUNT_SCALE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_GAIN_P:       gain_p_q       <= cfg_data[15:0];
				REG_GAIN_I:       gain_i_q       <= cfg_data[15:0];
				REG_GAIN_D:       gain_d_q       <= cfg_data[15:0];
				REG_MAX_INTEGRAL: max_integral_q <= cfg_data;
				REG_MAX_OUTPUT:   max_output_q   <= cfg_data[15:0];
				REG_COUNT_SCALE:  count_scale_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Per-motor state memory, read on acceptance and written back in the last step.
	mmepid_ram #(
		.WIDTH (STATE_W),
		.DEPTH (MOTOR_COUNT),
		.AW    (AW)
	) u_state_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_q),
		.wdata (ram_wword),
		.raddr (AW'(s_motor)),
		.rdata (ram_rdata)
	);

	// An entry never written since reset reads as all zeros.
	assign rd_word = valid_q[addr_q] ? mmepid_state_t'(ram_rdata) : '0;

	// Encoder unwrap: a jump of at least half the count range is a wrap.
	assign cnt_diff = $signed({1'b0, raw_q}) - $signed({1'b0, rd_word.prev_count});
	always_comb begin
		rev_next = rd_word.revolutions;
		if (cnt_diff > 17'sd32767) begin
			rev_next = rd_word.revolutions - 16'd1;
		end else if (cnt_diff < -17'sd32767) begin
			rev_next = rd_word.revolutions + 16'd1;
		end
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == ST_RD) begin
			mul_a = {{11{cmd_q[23]}}, cmd_q};
			mul_b = $signed({1'b0, count_scale_q});
		end else if (state_q == ST_ERR) begin
			mul_a = {{10{integ_q[24]}}, integ_q};
			mul_b = $signed({1'b0, gain_i_q});
		end else if (state_q == ST_MI) begin
			mul_a = {error_q[33], error_q};
			mul_b = $signed({1'b0, gain_p_q});
		end else if (state_q == ST_MP) begin
			mul_a = {error_q[33], error_q} - {lerr_q[33], lerr_q};
			mul_b = $signed({1'b0, gain_d_q});
		end
	end
	assign mul_p = mul_a * mul_b;

	// Output clamp and saturation.
	assign maxo_pos = $signed({37'd0, max_output_q});
	assign maxo_neg = -maxo_pos;
	assign sat_hi   = acc_q > maxo_pos;
	assign sat_lo   = acc_q < maxo_neg;
	assign sat      = sat_hi || sat_lo;
	assign out_pos  = (acc_q > 53'sd0) && !(sat && (max_output_q == 16'd0));
	assign acc_abs  = acc_q[52] ? -acc_q : acc_q;
	assign duty     = sat ? max_output_q : acc_abs[15:0];

	// Integral update with reset on saturation and symmetric clamp.
	assign integ_sum = {error_q[33], error_q} + {{10{integ_q[24]}}, integ_q};
	assign integ_pre = sat ? 35'sd0 : integ_sum;
	assign maxi_pos  = $signed({11'd0, max_integral_q});
	assign maxi_neg  = -maxi_pos;
	always_comb begin
		integ_cl = integ_pre;
		if (integ_pre > maxi_pos) begin
			integ_cl = maxi_pos;
		end else if (integ_pre < maxi_neg) begin
			integ_cl = maxi_neg;
		end
	end

	// Write-back word.
	assign ram_we                = (state_q == ST_OUT) && out_free && motor_ok_q;
	assign ram_wword.prev_count  = raw_q;
	assign ram_wword.revolutions = rev_q;
	assign ram_wword.integral    = integ_cl[24:0];
	assign ram_wword.last_error  = error_q;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						state_q <= s_motor_ok ? ST_RD : ST_OUT;
					end
				end
				ST_RD:  state_q <= ST_ERR;
				ST_ERR: state_q <= ST_MI;
				ST_MI:  state_q <= ST_MP;
				ST_MP:  state_q <= ST_MD;
				ST_MD:  state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (motor_ok_q) begin
							valid_q[addr_q] <= 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item capture and datapath.
	always_ff @(posedge clk) begin
		if (s_fire) begin
			motor_q    <= s_motor;
			raw_q      <= s_tdata[18:3];
			cmd_q      <= s_tdata[42:19];
			motor_ok_q <= s_motor_ok;
			addr_q     <= AW'(s_motor);
		end
		if (state_q == ST_RD) begin
			rev_q   <= rev_next;
			total_q <= {rev_next, raw_q};
			integ_q <= rd_word.integral;
			lerr_q  <= rd_word.last_error;
			mul_q   <= mul_p;
		end
		if (state_q == ST_ERR) begin
			// Setpoint is the floor of cmd * scale / 65536.
			error_q <= {{10{mul_q[39]}}, mul_q[39:16]} + {{2{total_q[31]}}, total_q};
			mul_q   <= mul_p;
		end
		if (state_q == ST_MI) begin
			acc_q <= {mul_q[51], mul_q};
			mul_q <= mul_p;
		end
		if (state_q == ST_MP) begin
			acc_q <= acc_q + {mul_q[51], mul_q};
			mul_q <= mul_p;
		end
		if (state_q == ST_MD) begin
			acc_q <= acc_q + {mul_q[51], mul_q};
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((state_q == ST_OUT) && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && out_free) begin
			if (motor_ok_q) begin
				m_tdata_q <= {3'd0, total_q, sat, duty, !out_pos, motor_q};
			end else begin
				m_tdata_q <= {3'd0, 32'd0, 1'b0, 16'd0, 1'b1, motor_q};
			end
		end
	end

endmodule
